FILE: design/kwm_pkg.sv
// kwm_pkg: shared types, action codes and default sizes for the k-way list merge core.
// No dependencies; imported by the top level and the merge sequencer.
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

  // default sizes, handed to the top-level parameters
  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int MAX_LISTS_DEF    = 16;
  localparam int DATA_WIDTH_DEF   = 32;

  // fixed widths of the channel fields
  localparam int ACTION_W    = 2;
  localparam int IN_VALUE_W  = 32;
  localparam int OUT_VALUE_W = 32;

  // request action codes; the unused code is ignored
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLOSE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MERGE  = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0]          action;
    logic signed [IN_VALUE_W-1:0] value;
  } kwm_in_t;

  typedef struct packed {
    logic signed [OUT_VALUE_W-1:0] merged_value;
    logic                          last;
    logic                          overflow;
  } kwm_out_t;

  // top -> merge sequencer
  typedef struct packed {
    logic start;
    logic clear;
  } kwm_seq_cmd_t;

  // merge sequencer -> top
  typedef struct packed {
    logic busy;
    logic done;
    logic src_sel;
  } kwm_seq_stat_t;

endpackage

`default_nettype wire

FILE: design/k_way_list_merge_core.sv
// k_way_list_merge_core: top level of the k-way list merge block (loader, emitter,
// ping-pong element banks). Depends on kwm_pkg, kwm_bank and kwm_merge_seq.
`timescale 1ns / 1ps
`default_nettype none

// Loads signed values list by list and, on a merge request, merges all lists with a
// pairwise merge tree and streams the merged elements out, the final one marked with
// last and every one carrying the overflow flag (elements dropped for lack of space).
// A merge request holds in_stall high until the whole set has been handed out. The
// merge runs ceil(log2(lists)) rounds, each merging the lists pairwise (a carried odd
// list counts as a pair), and a final check ends the merge. Elements move one per
// cycle through the single shared compare unit reading the source bank at two
// addresses and writing the other bank. The emit phase moves each element through a
// registered bank read, then the output register; the next element is read only once
// the output register has taken the previous one, which waits while out_stall is high.
// The element banks and length memory need no clearing: every length entry the tree
// reads is written during loading, and bank words are read only after being written.
module k_way_list_merge_core #(
  parameter int MAX_ELEMENTS = kwm_pkg::MAX_ELEMENTS_DEF,
  parameter int MAX_LISTS    = kwm_pkg::MAX_LISTS_DEF,
  parameter int DATA_WIDTH   = kwm_pkg::DATA_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire kwm_pkg::kwm_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output kwm_pkg::kwm_out_t     out_data
);

  import kwm_pkg::*;

  localparam int CW  = $clog2(MAX_ELEMENTS + 1);
  localparam int AW  = $clog2(MAX_ELEMENTS);
  localparam int LCW = $clog2(MAX_LISTS + 1);
  localparam int LAW = $clog2(MAX_LISTS);

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_MERGE = 4'b0010,
    T_RD    = 4'b0100,
    T_LD    = 4'b1000
  } top_state_t;

  top_state_t state_r, state_nxt;
  logic [CW-1:0]  total_r, total_nxt;    // elements stored
  logic [LCW-1:0] open_r, open_nxt;      // list now being filled
  logic [CW-1:0]  cur_len_r, cur_len_nxt; // length of the open list
  logic           dropped_r, dropped_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;        // emit pointer
  logic           out_valid_r, out_valid_nxt;
  kwm_out_t       out_data_r;

  logic           in_acc;
  logic           room, open_ok;
  logic           ld_we;
  logic [DATA_WIDTH-1:0] ld_data;
  logic           ld_len_we;
  logic [LCW-1:0] merge_count;
  logic           clear_now;
  logic           load_out;
  logic           is_last;

  kwm_seq_cmd_t   seq_cmd;
  kwm_seq_stat_t  seq_stat;
  logic [AW-1:0]  seq_rd_a, seq_rd_b, seq_wa;
  logic           seq_we;
  logic [DATA_WIDTH-1:0] seq_wd;

  logic [AW-1:0]  rd_a;
  logic           we0, we1;
  logic [AW-1:0]  wa0, wa1;
  logic [DATA_WIDTH-1:0] wd0, wd1;
  logic [DATA_WIDTH-1:0] q0_a, q0_b, q1_a, q1_b;
  logic [DATA_WIDTH-1:0] src_q_a, src_q_b;
  logic signed [DATA_WIDTH-1:0] emit_val;

  assign in_stall = (state_r != T_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign open_ok  = (open_r < LCW'(MAX_LISTS));
  assign room     = (total_r < CW'(MAX_ELEMENTS)) && open_ok;

  assign ld_we     = in_acc && (in_data.action == ACT_APPEND) && room;
  assign ld_data   = DATA_WIDTH'(in_data.value);
  // a close (plain or merging) records the open list's length
  assign ld_len_we = in_acc && open_ok &&
                     ((in_data.action == ACT_CLOSE) || (in_data.action == ACT_MERGE));
  // the merge runs over open+1 lists, capped at MAX_LISTS
  assign merge_count = open_ok ? (open_r + LCW'(1)) : open_r;

  assign is_last = (idx_r == (total_r - CW'(1)));

  always_comb begin
    state_nxt   = state_r;
    total_nxt   = total_r;
    open_nxt    = open_r;
    cur_len_nxt = cur_len_r;
    dropped_nxt = dropped_r;
    idx_nxt     = idx_r;
    clear_now   = 1'b0;
    load_out    = 1'b0;
    case (state_r)
      T_IDLE: begin
        if (in_acc) begin
          case (in_data.action)
            ACT_APPEND: begin
              if (room) begin
                total_nxt   = total_r + CW'(1);
                cur_len_nxt = cur_len_r + CW'(1);
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            ACT_CLOSE: begin
              if (open_ok) begin
                open_nxt    = open_r + LCW'(1);
                cur_len_nxt = '0;
              end
            end
            ACT_MERGE: begin
              state_nxt = T_MERGE;
            end
            default: begin
            end
          endcase
        end
      end
      T_MERGE: begin
        if (seq_stat.done) begin
          if (total_r == '0) begin
            // empty set: no results, state still cleared
            clear_now = 1'b1;
            state_nxt = T_IDLE;
          end else begin
            idx_nxt   = '0;
            state_nxt = T_RD;
          end
        end
      end
      T_RD: begin
        state_nxt = T_LD;
      end
      T_LD: begin
        if (!out_valid_r || !out_stall) begin
          load_out = 1'b1;
          if (is_last) begin
            clear_now = 1'b1;
            state_nxt = T_IDLE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = T_RD;
          end
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
    if (clear_now) begin
      total_nxt   = '0;
      open_nxt    = '0;
      cur_len_nxt = '0;
      dropped_nxt = 1'b0;
      idx_nxt     = '0;
    end
  end

  assign out_valid_nxt = load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      total_r     <= '0;
      open_r      <= '0;
      cur_len_r   <= '0;
      dropped_r   <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      open_r      <= open_nxt;
      cur_len_r   <= cur_len_nxt;
      dropped_r   <= dropped_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register, payload only
  assign emit_val = src_q_a;
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.merged_value <= OUT_VALUE_W'(emit_val);
      out_data_r.last         <= is_last;
      out_data_r.overflow     <= dropped_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // sequencer
  assign seq_cmd.start = in_acc && (in_data.action == ACT_MERGE);
  assign seq_cmd.clear = clear_now;

  kwm_merge_seq #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_LISTS    (MAX_LISTS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (seq_cmd),
    .count_i       (merge_count),
    .ld_len_we_i   (ld_len_we),
    .ld_len_addr_i (open_r[LAW-1:0]),
    .ld_len_data_i (cur_len_r),
    .q_a_i         (src_q_a),
    .q_b_i         (src_q_b),
    .rd_addr_a_o   (seq_rd_a),
    .rd_addr_b_o   (seq_rd_b),
    .wr_en_o       (seq_we),
    .wr_addr_o     (seq_wa),
    .wr_data_o     (seq_wd),
    .stat_o        (seq_stat)
  );

  // bank steering: loads and emits use the source bank, merge writes the other one
  assign rd_a = ((state_r == T_RD) || (state_r == T_LD)) ? idx_r[AW-1:0] : seq_rd_a;

  assign we0 = seq_stat.src_sel ? seq_we : ld_we;
  assign wa0 = seq_stat.src_sel ? seq_wa : total_r[AW-1:0];
  assign wd0 = seq_stat.src_sel ? seq_wd : ld_data;
  assign we1 = seq_stat.src_sel ? ld_we : seq_we;
  assign wa1 = seq_stat.src_sel ? total_r[AW-1:0] : seq_wa;
  assign wd1 = seq_stat.src_sel ? ld_data : seq_wd;

  assign src_q_a = seq_stat.src_sel ? q1_a : q0_a;
  assign src_q_b = seq_stat.src_sel ? q1_b : q0_b;

  kwm_bank #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (DATA_WIDTH)
  ) u_bank0 (
    .clk       (clk),
    .wr_en     (we0),
    .wr_addr   (wa0),
    .wr_data   (wd0),
    .rd_addr_a (rd_a),
    .rd_addr_b (seq_rd_b),
    .q_a       (q0_a),
    .q_b       (q0_b)
  );

  kwm_bank #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (DATA_WIDTH)
  ) u_bank1 (
    .clk       (clk),
    .wr_en     (we1),
    .wr_addr   (wa1),
    .wr_data   (wd1),
    .rd_addr_a (rd_a),
    .rd_addr_b (seq_rd_b),
    .q_a       (q1_a),
    .q_b       (q1_b)
  );

  a_idle_seq: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !seq_stat.busy)
    else $error("requests taken while the merge sequencer is busy");

  a_done_merge: assert property (@(posedge clk) disable iff (!rst_n)
    seq_stat.done |-> (state_r == T_MERGE))
    else $error("merge done outside the merge phase");

  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == T_RD) || (state_r == T_LD)) |-> (idx_r < total_r))
    else $error("emit pointer beyond stored elements");

endmodule

`default_nettype wire

FILE: design/kwm_bank.sv
// kwm_bank: one element bank, one write port and two registered read ports.
// Uses no package items; instantiated twice by the top level as a ping-pong pair.
`timescale 1ns / 1ps
`default_nettype none

module kwm_bank #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         q_a,
  output logic      [WIDTH-1:0]         q_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_a <= mem[rd_addr_a];
    q_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

FILE: design/kwm_merge_seq.sv
// kwm_merge_seq: pairwise merge-tree sequencer with the list length memory and the
// shared compare unit. Depends on kwm_pkg; drives the element banks through the top.
`timescale 1ns / 1ps
`default_nettype none

module kwm_merge_seq #(
  parameter int MAX_ELEMENTS = 64,
  parameter int MAX_LISTS    = 16,
  parameter int DATA_WIDTH   = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire kwm_pkg::kwm_seq_cmd_t               cmd_i,
  input  wire logic [$clog2(MAX_LISTS+1)-1:0]      count_i,
  input  wire logic                                ld_len_we_i,
  input  wire logic [$clog2(MAX_LISTS)-1:0]        ld_len_addr_i,
  input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0]   ld_len_data_i,
  input  wire logic [DATA_WIDTH-1:0]               q_a_i,
  input  wire logic [DATA_WIDTH-1:0]               q_b_i,
  output logic      [$clog2(MAX_ELEMENTS)-1:0]     rd_addr_a_o,
  output logic      [$clog2(MAX_ELEMENTS)-1:0]     rd_addr_b_o,
  output logic                                     wr_en_o,
  output logic      [$clog2(MAX_ELEMENTS)-1:0]     wr_addr_o,
  output logic      [DATA_WIDTH-1:0]               wr_data_o,
  output kwm_pkg::kwm_seq_stat_t                   stat_o
);

  import kwm_pkg::*;

  localparam int CW  = $clog2(MAX_ELEMENTS + 1);
  localparam int AW  = $clog2(MAX_ELEMENTS);
  localparam int LCW = $clog2(MAX_LISTS + 1);
  localparam int LAW = $clog2(MAX_LISTS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHK   = 7'b0000010,
    S_PAIR  = 7'b0000100,
    S_LENA  = 7'b0001000,
    S_LENB  = 7'b0010000,
    S_MRG   = 7'b0100000,
    S_ROUND = 7'b1000000
  } seq_state_t;

  seq_state_t state_r, state_nxt;
  logic [LCW-1:0] cnt_r, cnt_nxt;
  logic [LCW-1:0] j_r, j_nxt;
  logic [CW-1:0]  pos_r, pos_nxt;
  logic [CW-1:0]  la_r, la_nxt;
  logic [CW-1:0]  a_r, a_nxt, ea_r, ea_nxt;
  logic [CW-1:0]  b_r, b_nxt, eb_r, eb_nxt;
  logic [CW-1:0]  o_r, o_nxt;
  logic           src_r, src_nxt;

  // list length memory
  logic [CW-1:0]  len_mem [MAX_LISTS];
  logic [CW-1:0]  len_q_r;
  logic [LAW-1:0] len_rd_addr;
  logic           len_we;
  logic [LAW-1:0] len_wa;
  logic [CW-1:0]  len_wd;

  logic [LCW-1:0] half_up;
  logic [LCW:0]   idx_a, idx_b;
  logic           has_b;
  logic [CW-1:0]  lb;
  logic [CW-1:0]  sum_len;
  logic           a_done, b_done, take_a;

  assign half_up = (cnt_r >> 1) + LCW'(cnt_r[0]);
  assign idx_a   = {j_r, 1'b0};
  assign idx_b   = {j_r, 1'b1};
  assign has_b   = idx_b < {1'b0, cnt_r};
  assign lb      = has_b ? len_q_r : '0;
  assign sum_len = la_r + lb;
  assign a_done  = (a_r == ea_r);
  assign b_done  = (b_r == eb_r);
  // ties go to the later list
  assign take_a  = !a_done && (b_done || ($signed(q_a_i) < $signed(q_b_i)));

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    j_nxt       = j_r;
    pos_nxt     = pos_r;
    la_nxt      = la_r;
    a_nxt       = a_r;
    ea_nxt      = ea_r;
    b_nxt       = b_r;
    eb_nxt      = eb_r;
    o_nxt       = o_r;
    src_nxt     = src_r;
    len_rd_addr = idx_a[LAW-1:0];
    len_we      = ld_len_we_i;
    len_wa      = ld_len_addr_i;
    len_wd      = ld_len_data_i;
    wr_en_o     = 1'b0;
    wr_data_o   = q_a_i;
    case (state_r)
      S_IDLE: begin
        if (cmd_i.clear) begin
          src_nxt = 1'b0;
        end
        if (cmd_i.start) begin
          cnt_nxt   = count_i;
          j_nxt     = '0;
          pos_nxt   = '0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = (cnt_r <= LCW'(1)) ? S_IDLE : S_PAIR;
      end
      S_PAIR: begin
        state_nxt = (j_r == half_up) ? S_ROUND : S_LENA;
      end
      S_LENA: begin
        la_nxt      = len_q_r;
        len_rd_addr = idx_b[LAW-1:0];
        state_nxt   = S_LENB;
      end
      S_LENB: begin
        // odd last list runs as a pair with an empty partner: a plain copy
        a_nxt     = pos_r;
        ea_nxt    = pos_r + la_r;
        b_nxt     = pos_r + la_r;
        eb_nxt    = pos_r + sum_len;
        o_nxt     = pos_r;
        pos_nxt   = pos_r + sum_len;
        len_we    = 1'b1;
        len_wa    = j_r[LAW-1:0];
        len_wd    = sum_len;
        j_nxt     = j_r + LCW'(1);
        state_nxt = S_MRG;
      end
      S_MRG: begin
        if (a_done && b_done) begin
          state_nxt = S_PAIR;
        end else begin
          wr_en_o   = 1'b1;
          wr_data_o = take_a ? q_a_i : q_b_i;
          o_nxt     = o_r + CW'(1);
          if (take_a) begin
            a_nxt = a_r + CW'(1);
          end else begin
            b_nxt = b_r + CW'(1);
          end
        end
      end
      S_ROUND: begin
        cnt_nxt   = half_up;
        src_nxt   = !src_r;
        j_nxt     = '0;
        pos_nxt   = '0;
        state_nxt = S_CHK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // read at the next pointer so the registered data matches the pointer
  assign rd_addr_a_o = a_nxt[AW-1:0];
  assign rd_addr_b_o = b_nxt[AW-1:0];
  assign wr_addr_o   = o_r[AW-1:0];

  assign stat_o.busy    = (state_r != S_IDLE);
  assign stat_o.done    = (state_r == S_CHK) && (cnt_r <= LCW'(1));
  assign stat_o.src_sel = src_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      src_r   <= 1'b0;
      cnt_r   <= '0;
      j_r     <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      src_r   <= src_nxt;
      cnt_r   <= cnt_nxt;
      j_r     <= j_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    la_r <= la_nxt;
    a_r  <= a_nxt;
    ea_r <= ea_nxt;
    b_r  <= b_nxt;
    eb_r <= eb_nxt;
    o_r  <= o_nxt;
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_wa] <= len_wd;
    end
    len_q_r <= len_mem[len_rd_addr];
  end

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MRG) |-> (a_r <= ea_r) && (b_r <= eb_r))
    else $error("merge pointer ran past its list end");

  a_pair_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MRG) && a_done && b_done |-> (o_r == pos_r))
    else $error("pair written count differs from its list lengths");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.start |-> (state_r == S_IDLE))
    else $error("merge started while the sequencer was busy");

endmodule

`default_nettype wire
